FILE: rtl/core/krt_pkg.sv
package krt_pkg;

  // position field width of a response
  localparam int unsigned POS_W = 6;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_UPDATE = 3'd2,
    OP_DELETE = 3'd3,
    OP_LIST   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RESP,
    S_SHIFT,
    S_LIST
  } state_e;

  // one table entry as held in the record memory
  typedef struct packed {
    logic        [15:0] key_high;
    logic        [63:0] key_low;
    logic        [63:0] label_a;
    logic        [63:0] label_b;
    logic        [31:0] label_c;
    logic signed [31:0] price;
  } rec_t;

  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] position;
    rec_t             rec;
    logic             last;
  } res_t;

  // response handed from the sequencer to the output register
  typedef struct packed {
    logic load;
    res_t res;
  } emit_t;

endpackage

FILE: rtl/core/krt_req_if.sv
interface krt_req_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  opcode;
  logic        [15:0] key_high;
  logic        [63:0] key_low;
  logic        [63:0] label_a;
  logic        [63:0] label_b;
  logic        [31:0] label_c;
  logic signed [31:0] price;

  modport source (
    output valid, opcode, key_high, key_low, label_a, label_b, label_c, price,
    input  ready
  );
  modport sink (
    input  valid, opcode, key_high, key_low, label_a, label_b, label_c, price,
    output ready
  );
endinterface

FILE: rtl/core/krt_rsp_if.sv
interface krt_rsp_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  status;
  logic        [5:0]  position;
  logic        [15:0] out_key_high;
  logic        [63:0] out_key_low;
  logic        [63:0] out_label_a;
  logic        [63:0] out_label_b;
  logic        [31:0] out_label_c;
  logic signed [31:0] out_price;
  logic               last;

  modport source (
    output valid, status, position, out_key_high, out_key_low, out_label_a,
           out_label_b, out_label_c, out_price, last,
    input  ready
  );
  modport sink (
    input  valid, status, position, out_key_high, out_key_low, out_label_a,
           out_label_b, out_label_c, out_price, last,
    output ready
  );
endinterface

FILE: rtl/core/krt_ram.sv
module krt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/krt_ctrl.sv
module krt_ctrl import krt_pkg::*; #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  krt_req_if.sink       req_i,
  input  logic          slot_free_i,
  output emit_t         emit_o,
  output logic          rd_en_o,
  output logic [AW-1:0] rd_addr_o,
  input  rec_t          rd_data_i,
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output rec_t          wr_data_o
);

  state_e          state_q, state_d;
  op_e             op_q, op_d;
  rec_t            req_rec_q, req_rec_d;
  res_t            res_q, res_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   pend_idx_q, pend_idx_d;
  logic [CW-1:0]   count_q, count_d;
  logic            pend_q, pend_d;
  logic            del_q, del_d;

  op_e             in_op;
  rec_t            in_rec;
  logic            in_acc;
  logic            full;
  logic            more;
  logic            key_hit;
  logic            scan_miss;
  logic            list_emit;
  logic            list_rd;
  logic [CW-1:0]   pend_prev;
  logic [CW-1:0]   count_last;

  assign in_op  = op_e'(req_i.opcode);
  assign in_acc = req_i.valid && req_i.ready;
  assign full   = count_q >= CW'(CAPACITY);
  assign more   = idx_q < count_q;

  always_comb begin
    in_rec.key_high = req_i.key_high;
    in_rec.key_low  = req_i.key_low;
    in_rec.label_a  = req_i.label_a;
    in_rec.label_b  = req_i.label_b;
    in_rec.label_c  = req_i.label_c;
    in_rec.price    = req_i.price;
  end

  // pending read data belongs to entry pend_idx_q
  assign key_hit   = pend_q && (rd_data_i.key_high == req_rec_q.key_high)
                            && (rd_data_i.key_low == req_rec_q.key_low);
  assign scan_miss = !key_hit && (idx_q == count_q);
  assign list_emit = pend_q && slot_free_i;
  assign list_rd   = more && (!pend_q || list_emit);

  assign pend_prev  = pend_idx_q - CW'(1);
  assign count_last = count_q - CW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_INSERT: state_d = full ? S_RESP : S_SCAN;
            OP_LOOKUP, OP_UPDATE, OP_DELETE: state_d = S_SCAN;
            OP_LIST: state_d = (count_q == '0) ? S_RESP : S_LIST;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (key_hit || scan_miss) state_d = S_RESP;
      end
      S_RESP: begin
        if (slot_free_i) state_d = del_q ? S_SHIFT : S_IDLE;
      end
      S_SHIFT: begin
        if (!more && !pend_q) state_d = S_IDLE;
      end
      S_LIST: begin
        if (list_emit && (pend_idx_q == count_last)) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // memory control, response and handshake
  always_comb begin
    req_i.ready = (state_q == S_IDLE);
    rd_en_o     = 1'b0;
    rd_addr_o   = idx_q[AW-1:0];
    wr_en_o     = 1'b0;
    wr_addr_o   = '0;
    wr_data_o   = rd_data_i;
    emit_o      = '0;
    case (state_q)
      S_SCAN: begin
        rd_en_o = more;
        if (key_hit && (op_q == OP_UPDATE)) begin
          wr_en_o         = 1'b1;
          wr_addr_o       = pend_idx_q[AW-1:0];
          wr_data_o.price = req_rec_q.price;
        end else if (scan_miss && (op_q == OP_INSERT)) begin
          wr_en_o   = 1'b1;
          wr_addr_o = count_q[AW-1:0];
          wr_data_o = req_rec_q;
        end
      end
      S_RESP: begin
        emit_o.load = slot_free_i;
        emit_o.res  = res_q;
      end
      S_SHIFT: begin
        // entry k+1 moves down to k
        rd_en_o   = more;
        wr_en_o   = pend_q;
        wr_addr_o = pend_prev[AW-1:0];
      end
      S_LIST: begin
        rd_en_o             = list_rd;
        emit_o.load         = list_emit;
        emit_o.res.status   = ST_OK;
        emit_o.res.position = POS_W'(pend_idx_q);
        emit_o.res.rec      = rd_data_i;
        emit_o.res.last     = (pend_idx_q == count_last);
      end
      default: begin
      end
    endcase
  end

  // datapath registers
  always_comb begin
    op_d       = op_q;
    req_rec_d  = req_rec_q;
    res_d      = res_q;
    idx_d      = idx_q;
    pend_idx_d = pend_idx_q;
    count_d    = count_q;
    pend_d     = pend_q;
    del_d      = del_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d       = in_op;
          req_rec_d  = in_rec;
          idx_d      = '0;
          pend_d     = 1'b0;
          del_d      = 1'b0;
          res_d      = '0;
          res_d.last = 1'b1;
          if ((in_op == OP_INSERT) && full) res_d.status = ST_FULL;
          if ((in_op == OP_LIST) && (count_q == '0)) res_d.status = ST_EMPTY;
        end
      end
      S_SCAN: begin
        if (more) idx_d = idx_q + CW'(1);
        pend_d     = more;
        pend_idx_d = idx_q;
        if (key_hit) begin
          res_d.position = POS_W'(pend_idx_q);
          if (op_q == OP_INSERT) begin
            res_d.status = ST_DUP;
          end else begin
            res_d.status = ST_OK;
            res_d.rec    = rd_data_i;
          end
          if (op_q == OP_DELETE) begin
            del_d  = 1'b1;
            idx_d  = pend_idx_q + CW'(1);
            pend_d = 1'b0;
          end
        end else if (scan_miss) begin
          if (op_q == OP_INSERT) begin
            res_d.status   = ST_OK;
            res_d.position = POS_W'(count_q);
            res_d.rec      = req_rec_q;
            count_d        = count_q + CW'(1);
          end else begin
            res_d.status = ST_NOTFOUND;
          end
        end
      end
      S_SHIFT: begin
        if (more) idx_d = idx_q + CW'(1);
        pend_d     = more;
        pend_idx_d = idx_q;
        if (!more && !pend_q) count_d = count_last;
      end
      S_LIST: begin
        if (list_rd) begin
          idx_d      = idx_q + CW'(1);
          pend_idx_d = idx_q;
        end
        pend_d = list_rd || (pend_q && !list_emit);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      del_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      del_q   <= del_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    req_rec_q  <= req_rec_d;
    res_q      <= res_d;
    pend_idx_q <= pend_idx_d;
  end

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_read_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_o |-> (idx_q < count_q))
    else $error("read beyond last entry");

  a_shift_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && wr_en_o) |-> (pend_idx_q != '0 && pend_idx_q < count_q))
    else $error("shift writes outside table");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && scan_miss && op_q == OP_INSERT)
      |=> (count_q == CW'($past(count_q) + CW'(1))))
    else $error("insert did not grow table");

  a_list_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST && emit_o.load) |-> (pend_idx_q < count_q))
    else $error("list emits past last entry");

endmodule

FILE: rtl/core/keyed_record_table.sv
// channel  | dir | modport | carries
// req_i    | in  | sink    | opcode, key, label, price of one request
// rsp_o    | out | source  | status, position, entry fields, last
//
// lookup, update, delete and an insert into a table that is not full scan the entries
// from position 0 until the key is found or the entries run out; delete then moves each
// later entry down one place; list gives one entry per cycle while the output is free.
// rst_ni clears the entry count and the control state; the record memory is never cleared.
// a stalled response stops the sequencer, new requests wait while it is busy.
module keyed_record_table import krt_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  krt_req_if.sink   req_i,
  krt_rsp_if.source rsp_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned RW = $bits(rec_t);

  emit_t         emit;
  logic          slot_free;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  rec_t          rd_data;
  rec_t          wr_data;
  logic [RW-1:0] rd_raw;
  logic          out_v_q;
  res_t          out_res_q;

  krt_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .slot_free_i (slot_free),
    .emit_o      (emit),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  krt_ram #(
    .WIDTH (RW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_raw)
  );

  assign rd_data = rd_raw;

  // output register frees as the current response is taken
  assign slot_free = !out_v_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (emit.load) begin
      out_v_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      out_res_q <= emit.res;
    end
  end

  assign rsp_o.valid        = out_v_q;
  assign rsp_o.status       = out_res_q.status;
  assign rsp_o.position     = out_res_q.position;
  assign rsp_o.out_key_high = out_res_q.rec.key_high;
  assign rsp_o.out_key_low  = out_res_q.rec.key_low;
  assign rsp_o.out_label_a  = out_res_q.rec.label_a;
  assign rsp_o.out_label_b  = out_res_q.rec.label_b;
  assign rsp_o.out_label_c  = out_res_q.rec.label_c;
  assign rsp_o.out_price    = out_res_q.rec.price;
  assign rsp_o.last         = out_res_q.last;

endmodule
